// ===== rtl/xcfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types, codes and reset values of the XOR checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

	localparam int STORE_DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_DATA,
		RX_CHECK,
		RX_DRAIN
	} rx_state_t;

	typedef enum logic [2:0] {
		STS_ACK     = 3'd0,
		STS_NACK    = 3'd1,
		STS_FRAME   = 3'd2,
		STS_ERROR   = 3'd3,
		STS_TIMEOUT = 3'd4
	} status_t;

	localparam logic [2:0] REG_START   = 3'd0;
	localparam logic [2:0] REG_ACK     = 3'd1;
	localparam logic [2:0] REG_NACK    = 3'd2;
	localparam logic [2:0] REG_SEED    = 3'd3;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;

	localparam logic [7:0]  START_RST   = 8'd177;
	localparam logic [7:0]  ACK_RST     = 8'd6;
	localparam logic [7:0]  NACK_RST    = 8'd21;
	localparam logic [7:0]  SEED_RST    = 8'd255;
	localparam logic [15:0] TIMEOUT_RST = 16'd100;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/xor_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Byte stream deframer: start byte, length, payload, XOR check byte.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata = rx_byte, tuser = kind
// m_*       out  tvalid/tready      tdata = frame_byte, byte_index; tuser = status
// apb       in   psel/penable/...   registers 0..4 at byte address 4*i
//
// One input word per cycle while no frame drains; each result goes through
// a one-word output register, and input stalls only when that register is
// full and not taken. A good frame of n bytes drains from the frame memory
// at one word per cycle while m_tready holds (read port plus read register),
// input held meanwhile; arst_n clears control state and registers, not the frame memory.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver #(
	parameter int STORE_DEPTH = xcfr_pkg::STORE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
	output logic [2:0]       m_tuser,   // [2:0] status
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int FW = $clog2(STORE_DEPTH + 1);
	localparam logic [FW-1:0] DEPTH_F = FW'(STORE_DEPTH);

	logic [7:0]  start_q, ack_q, nack_q, seed_q;
	logic [15:0] timeout_q;

	xcfr_pkg::rx_state_t state_q, state_nxt;
	logic [FW-1:0] fill_q;
	logic [7:0]    len_q;
	logic [7:0]    chk_q;
	logic [15:0]   ticks_q;

	logic [7:0]    mem [STORE_DEPTH];
	logic [AW-1:0] rd_addr_q;
	logic [FW-1:0] rd_left_q;

	logic          valid_s1;
	logic [7:0]    rdata_s1;
	logic [AW-1:0] idx_s1;
	logic          last_s1;

	logic                out_valid_q;
	xcfr_pkg::status_t   status_q;
	logic [7:0]          byte_q;
	logic [5:0]          idx_q;
	logic                last_q;

	logic                accept, out_free, out_load_s1, issue;
	logic                emit;
	xcfr_pkg::status_t   emit_status;
	logic                mem_we;
	logic                fill_clr, fill_inc, len_ld, chk_seed_ld, chk_xor;
	logic                ticks_clr, ticks_inc, drain_start;
	logic [FW-1:0]       fill_nxt;
	logic [7:0]          len_cur;
	logic [15:0]         ticks_nxt;
	logic                cfg_wr;

	assign pready      = 1'b1;
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign out_free    = !out_valid_q || m_tready;
	assign s_tready    = (state_q != xcfr_pkg::RX_DRAIN) && out_free;
	assign accept      = s_tvalid && s_tready;
	assign out_load_s1 = valid_s1 && out_free;
	assign issue       = (state_q == xcfr_pkg::RX_DRAIN) && (rd_left_q != '0)
		&& (!valid_s1 || out_load_s1);

	assign fill_nxt  = fill_q + FW'(1);
	assign len_cur   = (fill_q == '0) ? s_tdata : len_q;
	assign ticks_nxt = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= xcfr_pkg::START_RST;
			ack_q     <= xcfr_pkg::ACK_RST;
			nack_q    <= xcfr_pkg::NACK_RST;
			seed_q    <= xcfr_pkg::SEED_RST;
			timeout_q <= xcfr_pkg::TIMEOUT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				xcfr_pkg::REG_START:   start_q   <= pwdata[7:0];
				xcfr_pkg::REG_ACK:     ack_q     <= pwdata[7:0];
				xcfr_pkg::REG_NACK:    nack_q    <= pwdata[7:0];
				xcfr_pkg::REG_SEED:    seed_q    <= pwdata[7:0];
				xcfr_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			xcfr_pkg::REG_START:   prdata = {24'd0, start_q};
			xcfr_pkg::REG_ACK:     prdata = {24'd0, ack_q};
			xcfr_pkg::REG_NACK:    prdata = {24'd0, nack_q};
			xcfr_pkg::REG_SEED:    prdata = {24'd0, seed_q};
			xcfr_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:               prdata = 32'd0;
		endcase
	end

	// next state and per-word actions
	always_comb begin
		state_nxt   = state_q;
		emit        = 1'b0;
		emit_status = xcfr_pkg::STS_ERROR;
		mem_we      = 1'b0;
		fill_clr    = 1'b0;
		fill_inc    = 1'b0;
		len_ld      = 1'b0;
		chk_seed_ld = 1'b0;
		chk_xor     = 1'b0;
		ticks_clr   = 1'b0;
		ticks_inc   = 1'b0;
		drain_start = 1'b0;
		unique case (state_q)
			xcfr_pkg::RX_IDLE: begin
				if (accept && s_tuser == xcfr_pkg::KIND_BYTE) begin
					if (s_tdata == start_q) begin
						state_nxt   = xcfr_pkg::RX_DATA;
						fill_clr    = 1'b1;
						chk_seed_ld = 1'b1;
						ticks_clr   = 1'b1;
					end else begin
						emit = 1'b1;
						if (s_tdata == ack_q)
							emit_status = xcfr_pkg::STS_ACK;
						else if (s_tdata == nack_q)
							emit_status = xcfr_pkg::STS_NACK;
						else
							emit_status = xcfr_pkg::STS_ERROR;
					end
				end
			end
			xcfr_pkg::RX_DATA, xcfr_pkg::RX_CHECK: begin
				if (accept && s_tuser == xcfr_pkg::KIND_TICK) begin
					ticks_inc = 1'b1;
					if (ticks_nxt >= timeout_q) begin
						state_nxt   = xcfr_pkg::RX_IDLE;
						emit        = 1'b1;
						emit_status = xcfr_pkg::STS_TIMEOUT;
					end
				end else if (accept && state_q == xcfr_pkg::RX_DATA) begin
					ticks_clr = 1'b1;
					if (fill_q < DEPTH_F) begin
						mem_we   = 1'b1;
						fill_inc = 1'b1;
						len_ld   = (fill_q == '0);
						chk_xor  = (fill_q != '0);
						if (8'(fill_nxt) == len_cur)
							state_nxt = xcfr_pkg::RX_CHECK;
					end else begin
						state_nxt   = xcfr_pkg::RX_IDLE;
						emit        = 1'b1;
						emit_status = xcfr_pkg::STS_ERROR;
					end
				end else if (accept) begin
					if (s_tdata == chk_q) begin
						state_nxt   = xcfr_pkg::RX_DRAIN;
						drain_start = 1'b1;
					end else begin
						state_nxt   = xcfr_pkg::RX_IDLE;
						emit        = 1'b1;
						emit_status = xcfr_pkg::STS_ERROR;
					end
				end
			end
			xcfr_pkg::RX_DRAIN: begin
				if (rd_left_q == '0 && !valid_s1)
					state_nxt = xcfr_pkg::RX_IDLE;
			end
			default: state_nxt = xcfr_pkg::RX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= xcfr_pkg::RX_IDLE;
		else
			state_q <= state_nxt;
	end

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			len_q     <= 8'd0;
			chk_q     <= 8'd0;
			ticks_q   <= 16'd0;
			rd_addr_q <= '0;
			rd_left_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (fill_clr)
				fill_q <= '0;
			else if (fill_inc)
				fill_q <= fill_nxt;
			if (len_ld)
				len_q <= s_tdata;
			if (chk_seed_ld)
				chk_q <= seed_q;
			else if (chk_xor)
				chk_q <= chk_q ^ s_tdata;
			if (ticks_clr)
				ticks_q <= 16'd0;
			else if (ticks_inc)
				ticks_q <= ticks_nxt;
			if (drain_start) begin
				rd_addr_q <= '0;
				rd_left_q <= fill_q;
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + AW'(1);
				rd_left_q <= rd_left_q - FW'(1);
			end
			valid_s1 <= issue || (valid_s1 && !out_load_s1);
		end
	end

	// frame memory: write port, registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[fill_q[AW-1:0]] <= s_tdata;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_addr_q];
			idx_s1   <= rd_addr_q;
			last_s1  <= (rd_left_q == FW'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else
			out_valid_q <= emit || out_load_s1 || (out_valid_q && !m_tready);
	end

	always_ff @(posedge clk) begin
		if (out_load_s1) begin
			status_q <= xcfr_pkg::STS_FRAME;
			byte_q   <= rdata_s1;
			idx_q    <= 6'(idx_s1);
			last_q   <= last_s1;
		end else if (emit) begin
			status_q <= emit_status;
			byte_q   <= 8'd0;
			idx_q    <= 6'd0;
			last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, idx_q, byte_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire
